/* rtl/css_pkg.sv */
`timescale 1ns / 1ps

package css_pkg;

   // Calendar limits.
   localparam logic [13:0] YEAR_MAX   = 14'd9999;
   localparam logic [3:0]  MONTH_MAX  = 4'd12;
   localparam logic [3:0]  MONTH_FEB  = 4'd2;
   localparam logic [4:0]  HOUR_MAX   = 5'd23;
   localparam logic [5:0]  MINUTE_MAX = 6'd59;
   localparam logic [5:0]  SECOND_MAX = 6'd59;
   localparam logic [4:0]  DAY_LONG   = 5'd31;

   // Year divided by 100 as (year * RECIP_100) >> RECIP_SHIFT, exact for every 14-bit year.
   localparam int          RECIP_SHIFT = 19;
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam logic [6:0]  CENTURY     = 7'd100;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEAP,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } stamp_type;

   typedef struct packed {
      stamp_type next;
      logic      year_fault;
      logic      year_change;
   } step_result_type;

   // Length of a month; months outside 1..12 count as 31 days.
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         MONTH_FEB: days = leap ? 5'd29 : 5'd28;
         4'd4:      days = 5'd30;
         4'd6:      days = 5'd30;
         4'd9:      days = 5'd30;
         4'd11:     days = 5'd30;
         default:   days = DAY_LONG;
      endcase
      return days;
   endfunction

endpackage

/* rtl/css_leap_unit.sv */
`timescale 1ns / 1ps

module css_leap_unit (
   input  logic        clock,
   input  logic        load,
   input  logic [13:0] year,
   output logic        leap
);
   import css_pkg::*;

   logic [13:0] year_ff;
   logic [7:0]  quot_ff;
   logic [26:0] prod;
   logic [14:0] back_prod;
   logic [13:0] rem;

   // The reciprocal product is registered before the second multiply.
   assign prod = 27'(year) * 27'(RECIP_100);

   always_ff @(posedge clock) begin
      if (load) begin
         year_ff <= year;
         quot_ff <= prod[RECIP_SHIFT +: 8];
      end
   end

   assign back_prod = 15'(quot_ff) * 15'(CENTURY);
   assign rem       = year_ff - back_prod[13:0];

   // A century year is a leap year only when its century count is a multiple of four.
   assign leap = (rem == 14'd0) ? (quot_ff[1:0] == 2'd0) : (year_ff[1:0] == 2'd0);

endmodule

/* rtl/css_step_unit.sv */
`timescale 1ns / 1ps

module css_step_unit (
   input  logic                     backward,
   input  logic                     leap,
   input  css_pkg::stamp_type       cur,
   output css_pkg::step_result_type result
);
   import css_pkg::*;

   logic [4:0] days_now;
   logic [4:0] days_prev;
   logic [3:0] month_dec;

   assign month_dec = cur.month - 4'd1;
   assign days_now  = month_days(cur.month, leap);
   assign days_prev = month_days(month_dec, leap);

   always_comb begin
      result             = '0;
      result.next        = cur;
      result.year_fault  = 1'b0;
      result.year_change = 1'b0;
      if (!backward) begin
         if (cur.second < SECOND_MAX) begin
            result.next.second = cur.second + 6'd1;
         end else begin
            result.next.second = 6'd0;
            if (cur.minute < MINUTE_MAX) begin
               result.next.minute = cur.minute + 6'd1;
            end else begin
               result.next.minute = 6'd0;
               if (cur.hour < HOUR_MAX) begin
                  result.next.hour = cur.hour + 5'd1;
               end else begin
                  result.next.hour = 5'd0;
                  if (cur.day < days_now) begin
                     result.next.day = cur.day + 5'd1;
                  end else begin
                     result.next.day = 5'd1;
                     if (cur.month < MONTH_MAX) begin
                        result.next.month = cur.month + 4'd1;
                     end else begin
                        result.next.month = 4'd1;
                        if (cur.year >= YEAR_MAX) begin
                           result.year_fault = 1'b1;
                        end else begin
                           result.next.year   = cur.year + 14'd1;
                           result.year_change = 1'b1;
                        end
                     end
                  end
               end
            end
         end
      end else begin
         if (cur.second > 6'd0) begin
            result.next.second = cur.second - 6'd1;
         end else begin
            result.next.second = SECOND_MAX;
            if (cur.minute > 6'd0) begin
               result.next.minute = cur.minute - 6'd1;
            end else begin
               result.next.minute = MINUTE_MAX;
               if (cur.hour > 5'd0) begin
                  result.next.hour = cur.hour - 5'd1;
               end else begin
                  result.next.hour = HOUR_MAX;
                  if (cur.day > 5'd1) begin
                     result.next.day = cur.day - 5'd1;
                  end else if (cur.month > 4'd1) begin
                     result.next.month = month_dec;
                     result.next.day   = days_prev;
                  end else if (cur.year == 14'd0) begin
                     result.year_fault = 1'b1;
                  end else begin
                     result.next.year   = cur.year - 14'd1;
                     result.next.month  = MONTH_MAX;
                     result.next.day    = DAY_LONG;
                     result.year_change = 1'b1;
                  end
               end
            end
         end
      end
   end

endmodule

/* rtl/calendar_second_stepper.sv */
`timescale 1ns / 1ps

// Calendar second stepper. A request beat carries a Gregorian date-time, a direction in
// req_tuser (0 adds, 1 subtracts) and a step count; the response beat carries that date-time
// moved by step_count seconds, with range_error in rsp_tuser when the year would leave
// 0..9999 (the starting date-time then comes back unchanged). After a request is accepted,
// ST_LEAP evaluates the leap year, ST_RUN moves one second per clock through a single shared
// step unit, and ST_DONE loads the response register once it is free; when the year rolls over
// mid-run, ST_LEAP evaluates the leap year again before stepping goes on. A starting year above
// 9999 or a zero count skips the stepping. The block takes one request at a time; a finished
// response waits in its own register, so the next request may be accepted and worked on while
// it is still unread.
module calendar_second_stepper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
   // second[39:34], step_count[47:40]
   input  logic [47:0] req_tdata,
   // op[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_year[13:0], new_month[17:14], new_day[22:18], new_hour[27:23],
   // new_minute[33:28], new_second[39:34]
   output logic [39:0] rsp_tdata,
   // range_error[0]
   output logic [0:0]  rsp_tuser
);
   import css_pkg::*;

   state_type       state_ff, state_in;
   stamp_type       start_ff, start_in;
   stamp_type       cur_ff, cur_in;
   logic            back_ff, back_in;
   logic [7:0]      count_ff, count_in;
   logic            err_ff, err_in;
   logic            rsp_valid_ff, rsp_valid_in;
   stamp_type       rsp_stamp_ff, rsp_stamp_in;
   logic            rsp_err_ff, rsp_err_in;

   logic            leap_load;
   logic            leap;
   step_result_type step;
   stamp_type       req_stamp;
   logic            req_beat;
   logic            out_free;

   assign req_stamp.year   = req_tdata[13:0];
   assign req_stamp.month  = req_tdata[17:14];
   assign req_stamp.day    = req_tdata[22:18];
   assign req_stamp.hour   = req_tdata[27:23];
   assign req_stamp.minute = req_tdata[33:28];
   assign req_stamp.second = req_tdata[39:34];

   // The leap year flag is loaded from cur_ff in ST_LEAP, before any step within that year.
   css_leap_unit u_leap (
      .clock (clock),
      .load  (leap_load),
      .year  (cur_ff.year),
      .leap  (leap)
   );

   css_step_unit u_step (
      .backward (back_ff),
      .leap     (leap),
      .cur      (cur_ff),
      .result   (step)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   // The response register is free when empty or when its beat is taken this cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      cur_ff       <= cur_in;
      back_ff      <= back_in;
      count_ff     <= count_in;
      err_ff       <= err_in;
      rsp_stamp_ff <= rsp_stamp_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      cur_in       = cur_ff;
      back_in      = back_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      rsp_stamp_in = rsp_stamp_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      leap_load    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               start_in = req_stamp;
               cur_in   = req_stamp;
               back_in  = req_tuser[0];
               count_in = req_tdata[47:40];
               // A year beyond the calendar is refused before any stepping.
               err_in   = (req_stamp.year > YEAR_MAX);
               if ((req_stamp.year > YEAR_MAX) || (req_tdata[47:40] == 8'd0)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LEAP;
               end
            end
         end
         ST_LEAP: begin
            leap_load = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (step.year_fault) begin
               // The year would leave the calendar; the start is reported as is.
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               cur_in   = step.next;
               count_in = count_ff - 8'd1;
               if (count_ff == 8'd1) begin
                  state_in = ST_DONE;
               end else if (step.year_change) begin
                  state_in = ST_LEAP;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_stamp_in = err_ff ? start_ff : cur_ff;
               rsp_err_in   = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_stamp_ff.second, rsp_stamp_ff.minute, rsp_stamp_ff.hour,
                        rsp_stamp_ff.day, rsp_stamp_ff.month, rsp_stamp_ff.year};
   assign rsp_tuser  = rsp_err_ff;

endmodule

/* rtl/css_checker.sv */
`timescale 1ns / 1ps

module css_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);
   import css_pkg::*;

   // A stalled response beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

   // Once a request beat is taken the block is busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // A response never appears in the cycle right after a request beat.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("response appeared too early");

   // A response without range error always carries a year inside the calendar.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[13:0] <= YEAR_MAX)
      else $error("year out of range without range error");

   // Reset empties the response register.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind calendar_second_stepper css_checker u_css_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
